// File: rtl/core/lfu_pkg.sv
// Shared types and constants for the LFU model cache directory.
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;

  localparam int unsigned BYTES_W = 36;
  localparam int unsigned USED_W  = 48;
  localparam int unsigned FREQ_W  = 32;
  localparam int unsigned PIN_W   = 16;
  localparam int unsigned MASK_W  = 4;
  localparam int unsigned SCALE_W = 8;
  localparam int unsigned PROD_W  = BYTES_W + SCALE_W;

  localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};
  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};
  localparam logic [PIN_W-1:0]  PIN_MAX  = {PIN_W{1'b1}};

  // Command codes.
  typedef enum logic [2:0] {
    CMD_SET_SIZE = 3'd0,
    CMD_CACHE_IN = 3'd1,
    CMD_EVICT    = 3'd2,
    CMD_FIND     = 3'd3,
    CMD_LOOKUP   = 3'd4,
    CMD_RELEASE  = 3'd5
  } cmd_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_LIMIT_A = 3'd0;
  localparam logic [2:0] REG_LIMIT_B = 3'd1;
  localparam logic [2:0] REG_LIMIT_C = 3'd2;
  localparam logic [2:0] REG_LIMIT_D = 3'd3;
  localparam logic [2:0] REG_SCALE   = 3'd4;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_EV_READ,
    ST_EV_EXEC,
    ST_NODE,
    ST_APPLY,
    ST_DONE
  } state_t;

  // One directory entry as held in the table memory.
  typedef struct packed {
    logic [BYTES_W-1:0] bytes;
    logic [FREQ_W-1:0]  freq;
    logic [PIN_W-1:0]   pins;
    logic [MASK_W-1:0]  mask;
    logic               cached;
  } entry_t;

  // Lowest set bit of a node mask, zero when empty.
  function automatic logic [1:0] lowest_node(input logic [MASK_W-1:0] m);
    logic [1:0] n;
    n = 2'd0;
    if (m[0]) n = 2'd0;
    else if (m[1]) n = 2'd1;
    else if (m[2]) n = 2'd2;
    else if (m[3]) n = 2'd3;
    return n;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/lfu_table.sv
// Single-port directory table memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lfu_table #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = 8
) (
  input  wire                  clk,
  input  wire                  wr_en,
  input  wire [ADDR_W-1:0]     addr,
  input  wire lfu_pkg::entry_t wr_data,
  output lfu_pkg::entry_t      rd_data
);

  lfu_pkg::entry_t mem [DEPTH];

  // Read-first: a write and a read of the same entry in one cycle return the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    rd_data <= mem[addr];
  end

endmodule
`default_nettype wire

// File: rtl/core/lfu_model_cache_directory.sv
// Top level of the LFU model cache directory: sequencer, node usage and table.
// Evict scans the whole table, reading one table entry per cycle, before its result;
// of the other commands, find space is the longest.
// One request is handled at a time; the next is taken once the result is delivered.
// After reset a clearing pass writes every table entry, during which no request is
// taken; configuration writes are accepted throughout.
`timescale 1ns / 1ps
`default_nettype none
module lfu_model_cache_directory #(
  parameter int unsigned NUM_MODELS = 256,
  parameter int unsigned NUM_NODES  = 4
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire [2:0]   cfg_index,
  input  wire [47:0]  cfg_data,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire [2:0]   cmd,
  input  wire [7:0]   model_index,
  input  wire [1:0]   node_index,
  input  wire [35:0]  byte_count,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        status,
  output logic [1:0]  node_out,
  output logic [7:0]  model_out,
  output logic [47:0] free_room
);

  localparam int unsigned ADDR_W = (NUM_MODELS > 1) ? $clog2(NUM_MODELS) : 1;
  localparam int unsigned CNT_W  = ADDR_W;
  localparam int unsigned USED_W = lfu_pkg::USED_W;

  // Configuration registers.
  logic [USED_W-1:0] node_limit [4];
  logic [7:0]        size_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) node_limit[i] <= '0;
      size_scale <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        lfu_pkg::REG_LIMIT_A: node_limit[0] <= cfg_data;
        lfu_pkg::REG_LIMIT_B: node_limit[1] <= cfg_data;
        lfu_pkg::REG_LIMIT_C: node_limit[2] <= cfg_data;
        lfu_pkg::REG_LIMIT_D: node_limit[3] <= cfg_data;
        lfu_pkg::REG_SCALE:   size_scale    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer registers.
  lfu_pkg::state_t state, state_next;
  logic [CNT_W-1:0]  cnt;
  logic [2:0]        r_cmd;
  logic [7:0]        r_model;
  logic [1:0]        r_node;
  logic [35:0]       r_bytes;
  logic              r_ok;
  logic              found;
  logic [ADDR_W-1:0] best;
  logic [31:0]       best_freq;
  lfu_pkg::entry_t   r_ent;
  logic [USED_W-1:0] node_used [4];
  logic [USED_W-1:0] prod;
  logic [2:0]        sel;
  logic [1:0]        fn;
  logic [USED_W-1:0] froom;
  logic              ffound;

  lfu_pkg::entry_t   tbl_rd, tbl_wd;
  logic              tbl_we;
  logic [ADDR_W-1:0] tbl_addr;

  lfu_table #(.DEPTH(NUM_MODELS), .ADDR_W(ADDR_W)) u_table (
    .clk    (clk),
    .wr_en  (tbl_we),
    .addr   (tbl_addr),
    .wr_data(tbl_wd),
    .rd_data(tbl_rd)
  );

  wire accept = in_valid && !in_stall;
  wire cnt_last = (cnt[ADDR_W-1:0] == ADDR_W'(NUM_MODELS - 1));
  wire cand = tbl_rd.cached && (tbl_rd.pins == '0) &&
              (!found || tbl_rd.freq < best_freq);

  // Find-space candidate for the node under test.
  logic [USED_W-1:0] avail;
  always_comb begin
    avail = (node_used[sel[1:0]] > node_limit[sel[1:0]]) ? '0 :
            node_limit[sel[1:0]] - node_used[sel[1:0]];
  end

  // Shared size-times-scale multiplier for charging and refunding usage.
  logic [35:0]       mul_bytes;
  logic [USED_W-1:0] charge;
  always_comb begin
    mul_bytes = (state == lfu_pkg::ST_EV_EXEC) ? tbl_rd.bytes : r_ent.bytes;
    charge = USED_W'(mul_bytes) * USED_W'(size_scale);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lfu_pkg::ST_CLEAR: if (cnt_last) state_next = lfu_pkg::ST_IDLE;
      lfu_pkg::ST_IDLE:  if (accept) state_next = lfu_pkg::ST_READ;
      lfu_pkg::ST_READ: begin
        case (r_cmd)
          lfu_pkg::CMD_EVICT: state_next = lfu_pkg::ST_SCAN;
          lfu_pkg::CMD_FIND:  state_next = lfu_pkg::ST_NODE;
          default:            state_next = lfu_pkg::ST_EXEC;
        endcase
      end
      lfu_pkg::ST_EXEC: begin
        if (r_cmd == lfu_pkg::CMD_CACHE_IN && r_ok &&
            !r_ent.mask[r_node])
          state_next = lfu_pkg::ST_APPLY;
        else
          state_next = lfu_pkg::ST_DONE;
      end
      lfu_pkg::ST_SCAN:      if (cnt_last) state_next = lfu_pkg::ST_SCAN_LAST;
      lfu_pkg::ST_SCAN_LAST: state_next = lfu_pkg::ST_EV_READ;
      lfu_pkg::ST_EV_READ:   state_next = found ? lfu_pkg::ST_EV_EXEC : lfu_pkg::ST_DONE;
      lfu_pkg::ST_EV_EXEC:   state_next = lfu_pkg::ST_APPLY;
      lfu_pkg::ST_NODE:      if (sel == 3'(NUM_NODES - 1)) state_next = lfu_pkg::ST_DONE;
      lfu_pkg::ST_APPLY:     state_next = lfu_pkg::ST_DONE;
      lfu_pkg::ST_DONE:      if (!out_stall) state_next = lfu_pkg::ST_IDLE;
      default:               state_next = lfu_pkg::ST_IDLE;
    endcase
  end

  // Outputs and table port control.
  always_comb begin
    in_stall = (state != lfu_pkg::ST_IDLE);
    out_valid = (state == lfu_pkg::ST_DONE);
    tbl_we = 1'b0;
    tbl_addr = r_model[ADDR_W-1:0];
    tbl_wd = r_ent;
    case (state)
      lfu_pkg::ST_CLEAR: begin
        tbl_we = 1'b1;
        tbl_addr = cnt[ADDR_W-1:0];
        tbl_wd = '0;
      end
      // The entry of an incoming request is read as it is accepted.
      lfu_pkg::ST_IDLE: tbl_addr = ADDR_W'(model_index);
      lfu_pkg::ST_SCAN: tbl_addr = cnt[ADDR_W-1:0];
      lfu_pkg::ST_EV_READ: tbl_addr = best;
      lfu_pkg::ST_EXEC: begin
        tbl_we = r_ok && (r_cmd == lfu_pkg::CMD_SET_SIZE ||
                          r_cmd == lfu_pkg::CMD_CACHE_IN ||
                          r_cmd == lfu_pkg::CMD_RELEASE);
        case (r_cmd)
          lfu_pkg::CMD_SET_SIZE: tbl_wd.bytes = r_bytes;
          lfu_pkg::CMD_CACHE_IN: begin
            if (r_ent.freq != lfu_pkg::FREQ_MAX) tbl_wd.freq = r_ent.freq + 32'd1;
            if (r_ent.pins != lfu_pkg::PIN_MAX)  tbl_wd.pins = r_ent.pins + 16'd1;
            tbl_wd.mask[r_node] = 1'b1;
            tbl_wd.cached = 1'b1;
          end
          lfu_pkg::CMD_RELEASE:
            if (r_ent.pins != '0) tbl_wd.pins = r_ent.pins - 16'd1;
          default: ;
        endcase
      end
      lfu_pkg::ST_EV_EXEC: begin
        tbl_we = 1'b1;
        tbl_addr = best;
        tbl_wd = tbl_rd;
        tbl_wd.cached = 1'b0;
        if (tbl_rd.mask != '0) tbl_wd.mask[lfu_pkg::lowest_node(tbl_rd.mask)] = 1'b0;
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lfu_pkg::ST_CLEAR;
      cnt <= '0;
      for (int i = 0; i < 4; i++) node_used[i] <= '0;
    end else begin
      state <= state_next;
      if (state == lfu_pkg::ST_CLEAR || state == lfu_pkg::ST_SCAN)
        cnt <= cnt_last ? '0 : cnt + CNT_W'(1);
      // Usage update: charge on cache-in, refund on evict.
      if (state == lfu_pkg::ST_APPLY) begin
        if (r_cmd == lfu_pkg::CMD_CACHE_IN) begin
          node_used[r_node] <= (prod > lfu_pkg::USED_MAX - node_used[r_node]) ?
                               lfu_pkg::USED_MAX : node_used[r_node] + prod;
        end else if (r_ent.mask != '0) begin
          node_used[fn] <= (prod > node_used[fn]) ? '0 : node_used[fn] - prod;
        end
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (state)
      lfu_pkg::ST_IDLE: if (accept) begin
        r_cmd   <= cmd;
        r_model <= model_index;
        r_node  <= node_index;
        r_bytes <= byte_count;
        r_ok    <= (32'(model_index) < NUM_MODELS) &&
                   (cmd != lfu_pkg::CMD_CACHE_IN || 32'(node_index) < NUM_NODES);
        found   <= 1'b0;
        ffound  <= 1'b0;
        sel     <= '0;
        best    <= '0;
        best_freq <= '0;
        status <= 1'b1; node_out <= '0; model_out <= '0; free_room <= '0;
      end
      lfu_pkg::ST_EXEC: begin
        prod <= charge;
        if (r_ok) begin
          case (r_cmd)
            lfu_pkg::CMD_SET_SIZE, lfu_pkg::CMD_CACHE_IN, lfu_pkg::CMD_RELEASE:
              status <= 1'b0;
            lfu_pkg::CMD_LOOKUP: if (r_ent.mask != '0) begin
              status <= 1'b0;
              node_out <= lfu_pkg::lowest_node(r_ent.mask);
            end
            default: ;
          endcase
        end
      end
      lfu_pkg::ST_SCAN, lfu_pkg::ST_SCAN_LAST: begin
        // Entry read in the previous cycle is compared now.
        if (!(state == lfu_pkg::ST_SCAN && cnt == '0) && cand) begin
          found <= 1'b1;
          best <= (state == lfu_pkg::ST_SCAN_LAST) ? ADDR_W'(NUM_MODELS - 1) :
                  cnt[ADDR_W-1:0] - ADDR_W'(1);
          best_freq <= tbl_rd.freq;
        end
      end
      lfu_pkg::ST_EV_EXEC: begin
        prod <= charge;
        fn <= lfu_pkg::lowest_node(tbl_rd.mask);
        status <= 1'b0;
        model_out <= 8'(best);
        node_out <= lfu_pkg::lowest_node(tbl_rd.mask);
      end
      lfu_pkg::ST_NODE: begin
        if (avail >= USED_W'(r_bytes) && (!ffound || avail > froom)) begin
          ffound <= 1'b1;
          froom <= avail;
          status <= 1'b0;
          node_out <= sel[1:0];
          free_room <= avail;
        end
        sel <= sel + 3'd1;
      end
      default: ;
    endcase
    if (state == lfu_pkg::ST_READ || state == lfu_pkg::ST_EV_EXEC) r_ent <= tbl_rd;
  end

endmodule
`default_nettype wire
